// ===== rtl/opha_pkg.sv =====
// ----------------------------------------------------------------------------
// opha_pkg
// Shared types and codes for the object pool handle allocator.
// ----------------------------------------------------------------------------
package opha_pkg;

  localparam int unsigned ReqW = 3;
  localparam int unsigned HandleW = 10;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW = 11;

  localparam logic [ReqW-1:0] REQ_ALLOC = 3'd0;
  localparam logic [ReqW-1:0] REQ_FREE  = 3'd1;
  localparam logic [ReqW-1:0] REQ_CLEAN = 3'd2;
  localparam logic [ReqW-1:0] REQ_FIRST = 3'd3;
  localparam logic [ReqW-1:0] REQ_NEXT  = 3'd4;
  localparam logic [ReqW-1:0] REQ_DEAD  = 3'd5;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] ST_DBL   = 2'd2;
  localparam logic [StatusW-1:0] ST_END   = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,
    OP_LOAD,
    OP_SET_EMPTY,
    OP_ALLOC_RD,
    OP_ALLOC_LINK,
    OP_ALLOC_FIN,
    OP_SET_DBL,
    OP_SET_DEAD,
    OP_DEAD_RD,
    OP_DEAD_CHK,
    OP_CLEAN_RD,
    OP_CLEAN_LINK,
    OP_CLEAN_WR,
    OP_CLEAN_END,
    OP_WALK_HEAD,
    OP_NEXT_RD,
    OP_WALK_NX,
    OP_WALK_RD,
    OP_WALK_STEP,
    OP_WALK_FOUND,
    OP_SET_END,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic            init_done;
    logic [ReqW-1:0] req;
    logic            depth_zero;
    logic            h_valid;
    logic            dead_rd;
    logic            p_valid;
    logic            steps_max;
    logic            clean_done;
    logic            out_busy;
  } dp_stat_t;

endpackage

// ===== rtl/opha_dp.sv =====
// ----------------------------------------------------------------------------
// opha_dp
// Datapath: pool memories, list head, counters and result registers.
// ----------------------------------------------------------------------------
module opha_dp #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  opha_pkg::dp_cmd_t   cmd_i,
  output opha_pkg::dp_stat_t  stat_o,
  input  logic [15:0]         in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [23:0]         out_data_o
);
  import opha_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NullLink = LW'(CAPACITY);
  localparam logic [AW-1:0] LastIdx = AW'(CAPACITY - 1);

  logic [AW-1:0] fs_mem   [CAPACITY];
  logic          dead_mem [CAPACITY];
  logic [LW-1:0] nx_mem   [CAPACITY];
  logic [LW-1:0] pv_mem   [CAPACITY];
  logic [AW-1:0] pf_mem   [CAPACITY];

  logic [AW-1:0] fs_rd_q, pf_rd_q;
  logic          dead_rd_q;
  logic [LW-1:0] nx_rd_q, pv_rd_q;

  logic [LW-1:0] depth_q, depth_d, head_q, head_d, pcnt_q, pcnt_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [ReqW-1:0] req_q, req_d;
  logic [HandleW-1:0] h_q, h_d;
  logic [AW-1:0] s_q, s_d;
  logic [LW-1:0] p_q, p_d, steps_q, steps_d, recl_q, recl_d;
  logic [AW-1:0] res_q, res_d;
  logic [StatusW-1:0] st_q, st_d;
  logic dflag_q, dflag_d;
  logic ovalid_q, ovalid_d;
  logic [23:0] odata_q, odata_d;

  logic          fs_we, dead_we, nx_we, pv_we, pf_we;
  logic [AW-1:0] fs_wa, dead_wa, nx_wa, pv_wa, pf_wa;
  logic [AW-1:0] fs_wd, pf_wd;
  logic          dead_wd;
  logic [LW-1:0] nx_wd, pv_wd;
  logic          fs_re, dead_re, nx_re, pv_re, pf_re;
  logic [AW-1:0] fs_ra, dead_ra, nx_ra, pv_ra, pf_ra;

  logic [AW-1:0] h_idx;
  logic          h_valid;
  logic [LW-1:0] depth_m1;

  assign h_idx    = AW'(h_q);
  assign h_valid  = 32'(h_q) < CAPACITY;
  assign depth_m1 = depth_q - LW'(1);

  always_comb begin
    stat_o.init_done  = (clr_q == LastIdx);
    stat_o.req        = req_q;
    stat_o.depth_zero = (depth_q == '0);
    stat_o.h_valid    = h_valid;
    stat_o.dead_rd    = dead_rd_q;
    stat_o.p_valid    = (p_q < NullLink);
    stat_o.steps_max  = (steps_q >= NullLink);
    stat_o.clean_done = (recl_q == pcnt_q);
    stat_o.out_busy   = ovalid_q && !out_ready_i;
  end

  always_comb begin
    fs_we = 1'b0; fs_wa = '0; fs_wd = '0;
    dead_we = 1'b0; dead_wa = '0; dead_wd = 1'b0;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
    pf_we = 1'b0; pf_wa = '0; pf_wd = '0;
    fs_re = 1'b0; fs_ra = depth_m1[AW-1:0];
    dead_re = 1'b0; dead_ra = h_idx;
    nx_re = 1'b0; nx_ra = h_idx;
    pv_re = 1'b0; pv_ra = pf_rd_q;
    pf_re = 1'b0; pf_ra = recl_q[AW-1:0];
    depth_d = depth_q; head_d = head_q; pcnt_d = pcnt_q; clr_d = clr_q;
    req_d = req_q; h_d = h_q; s_d = s_q; p_d = p_q; steps_d = steps_q;
    recl_d = recl_q; res_d = res_q; st_d = st_q; dflag_d = dflag_q;
    ovalid_d = ovalid_q && !out_ready_i;
    odata_d = odata_q;

    unique case (cmd_i.op)
      OP_INIT: begin
        fs_we = 1'b1; fs_wa = clr_q; fs_wd = clr_q;
        dead_we = 1'b1; dead_wa = clr_q; dead_wd = 1'b1;
        nx_we = 1'b1; nx_wa = clr_q; nx_wd = NullLink;
        pv_we = 1'b1; pv_wa = clr_q; pv_wd = NullLink;
        if (clr_q != LastIdx) clr_d = clr_q + AW'(1);
      end
      OP_LOAD: begin
        req_d = in_data_i[2:0];
        h_d = in_data_i[12:3];
        res_d = '0; st_d = ST_OK; dflag_d = 1'b0; recl_d = '0;
      end
      OP_SET_EMPTY: st_d = ST_EMPTY;
      OP_ALLOC_RD: fs_re = 1'b1;
      OP_ALLOC_LINK: begin
        s_d = fs_rd_q;
        dead_we = 1'b1; dead_wa = fs_rd_q; dead_wd = 1'b0;
        nx_we = 1'b1; nx_wa = fs_rd_q; nx_wd = head_q;
        if (head_q < NullLink) begin
          pv_we = 1'b1; pv_wa = head_q[AW-1:0]; pv_wd = LW'(fs_rd_q);
        end
      end
      OP_ALLOC_FIN: begin
        pv_we = 1'b1; pv_wa = s_q; pv_wd = NullLink;
        head_d = LW'(s_q);
        depth_d = depth_m1;
        res_d = s_q;
      end
      OP_SET_DBL: st_d = ST_DBL;
      OP_SET_DEAD: dflag_d = 1'b1;
      OP_DEAD_RD: dead_re = 1'b1;
      OP_DEAD_CHK: begin
        if (req_q == REQ_FREE) begin
          if (dead_rd_q) begin
            st_d = ST_DBL;
          end else begin
            dead_we = 1'b1; dead_wa = h_idx; dead_wd = 1'b1;
            if (pcnt_q < NullLink) begin
              pf_we = 1'b1; pf_wa = pcnt_q[AW-1:0]; pf_wd = h_idx;
              pcnt_d = pcnt_q + LW'(1);
            end
          end
        end else begin
          dflag_d = dead_rd_q;
        end
      end
      OP_CLEAN_RD: pf_re = 1'b1;
      OP_CLEAN_LINK: begin
        s_d = pf_rd_q;
        nx_re = 1'b1; nx_ra = pf_rd_q;
        pv_re = 1'b1;
      end
      OP_CLEAN_WR: begin
        if (nx_rd_q < NullLink) begin
          pv_we = 1'b1; pv_wa = nx_rd_q[AW-1:0]; pv_wd = pv_rd_q;
        end
        if (pv_rd_q < NullLink) begin
          nx_we = 1'b1; nx_wa = pv_rd_q[AW-1:0]; nx_wd = nx_rd_q;
        end
        if (head_q == LW'(s_q)) head_d = nx_rd_q;
        if (depth_q < NullLink) begin
          fs_we = 1'b1; fs_wa = depth_q[AW-1:0]; fs_wd = s_q;
          depth_d = depth_q + LW'(1);
        end
        recl_d = recl_q + LW'(1);
      end
      OP_CLEAN_END: pcnt_d = '0;
      OP_WALK_HEAD: begin
        p_d = head_q; steps_d = '0;
      end
      OP_NEXT_RD: nx_re = 1'b1;
      OP_WALK_NX: begin
        p_d = nx_rd_q; steps_d = '0;
      end
      OP_WALK_RD: begin
        dead_re = 1'b1; dead_ra = p_q[AW-1:0];
        nx_re = 1'b1; nx_ra = p_q[AW-1:0];
      end
      OP_WALK_STEP: begin
        steps_d = steps_q + LW'(1);
        p_d = nx_rd_q;
      end
      OP_WALK_FOUND: res_d = p_q[AW-1:0];
      OP_SET_END: st_d = ST_END;
      OP_OUT: begin
        ovalid_d = 1'b1;
        odata_d = {dflag_q, CountW'(recl_q), st_q, HandleW'(res_q)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fs_we) fs_mem[fs_wa] <= fs_wd;
    if (fs_re) fs_rd_q <= fs_mem[fs_ra];
  end

  always_ff @(posedge clk_i) begin
    if (dead_we) dead_mem[dead_wa] <= dead_wd;
    if (dead_re) dead_rd_q <= dead_mem[dead_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    if (nx_re) nx_rd_q <= nx_mem[nx_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    if (pv_re) pv_rd_q <= pv_mem[pv_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pf_we) pf_mem[pf_wa] <= pf_wd;
    if (pf_re) pf_rd_q <= pf_mem[pf_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= NullLink;
      head_q   <= NullLink;
      pcnt_q   <= '0;
      clr_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      depth_q  <= depth_d;
      head_q   <= head_d;
      pcnt_q   <= pcnt_d;
      clr_q    <= clr_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    h_q     <= h_d;
    s_q     <= s_d;
    p_q     <= p_d;
    steps_q <= steps_d;
    recl_q  <= recl_d;
    res_q   <= res_d;
    st_q    <= st_d;
    dflag_q <= dflag_d;
    odata_q <= odata_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

endmodule

// ===== rtl/opha_ctrl.sv =====
// ----------------------------------------------------------------------------
// opha_ctrl
// Request sequencer: steps the datapath through each request.
// ----------------------------------------------------------------------------
module opha_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output opha_pkg::dp_cmd_t   cmd_o,
  input  opha_pkg::dp_stat_t  stat_i
);
  import opha_pkg::*;

  typedef enum logic [15:0] {
    S_INIT       = 16'b0000_0000_0000_0001,
    S_IDLE       = 16'b0000_0000_0000_0010,
    S_DECODE     = 16'b0000_0000_0000_0100,
    S_ALLOC_LINK = 16'b0000_0000_0000_1000,
    S_ALLOC_FIN  = 16'b0000_0000_0001_0000,
    S_DEAD_CHK   = 16'b0000_0000_0010_0000,
    S_CLEAN_CHK  = 16'b0000_0000_0100_0000,
    S_CLEAN_LINK = 16'b0000_0000_1000_0000,
    S_CLEAN_WR   = 16'b0000_0001_0000_0000,
    S_WALK_NX    = 16'b0000_0010_0000_0000,
    S_WALK_CHK   = 16'b0000_0100_0000_0000,
    S_WALK_EVAL  = 16'b0000_1000_0000_0000,
    S_DONE       = 16'b0001_0000_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.op = OP_INIT;
        if (stat_i.init_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.req) inside
          REQ_ALLOC: begin
            if (stat_i.depth_zero) begin
              cmd_o.op = OP_SET_EMPTY;
              state_d = S_DONE;
            end else begin
              cmd_o.op = OP_ALLOC_RD;
              state_d = S_ALLOC_LINK;
            end
          end
          REQ_FREE, REQ_DEAD: begin
            if (!stat_i.h_valid) begin
              cmd_o.op = (stat_i.req == REQ_FREE) ? OP_SET_DBL : OP_SET_DEAD;
              state_d = S_DONE;
            end else begin
              cmd_o.op = OP_DEAD_RD;
              state_d = S_DEAD_CHK;
            end
          end
          REQ_CLEAN: state_d = S_CLEAN_CHK;
          REQ_FIRST: begin
            cmd_o.op = OP_WALK_HEAD;
            state_d = S_WALK_CHK;
          end
          REQ_NEXT: begin
            if (!stat_i.h_valid) begin
              cmd_o.op = OP_SET_END;
              state_d = S_DONE;
            end else begin
              cmd_o.op = OP_NEXT_RD;
              state_d = S_WALK_NX;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_ALLOC_LINK: begin
        cmd_o.op = OP_ALLOC_LINK;
        state_d = S_ALLOC_FIN;
      end
      S_ALLOC_FIN: begin
        cmd_o.op = OP_ALLOC_FIN;
        state_d = S_DONE;
      end
      S_DEAD_CHK: begin
        cmd_o.op = OP_DEAD_CHK;
        state_d = S_DONE;
      end
      S_CLEAN_CHK: begin
        if (stat_i.clean_done) begin
          cmd_o.op = OP_CLEAN_END;
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_CLEAN_RD;
          state_d = S_CLEAN_LINK;
        end
      end
      S_CLEAN_LINK: begin
        cmd_o.op = OP_CLEAN_LINK;
        state_d = S_CLEAN_WR;
      end
      S_CLEAN_WR: begin
        cmd_o.op = OP_CLEAN_WR;
        state_d = S_CLEAN_CHK;
      end
      S_WALK_NX: begin
        cmd_o.op = OP_WALK_NX;
        state_d = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (!stat_i.p_valid) begin
          cmd_o.op = OP_SET_END;
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_WALK_RD;
          state_d = S_WALK_EVAL;
        end
      end
      S_WALK_EVAL: begin
        if (!stat_i.dead_rd) begin
          cmd_o.op = OP_WALK_FOUND;
          state_d = S_DONE;
        end else if (stat_i.steps_max) begin
          cmd_o.op = OP_SET_END;
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_WALK_STEP;
          state_d = S_WALK_CHK;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/object_pool_handle_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// object_pool_handle_allocator_unit
// Fixed-capacity handle allocator with live list and deferred free queue.
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over every entry of its
// memories before it takes the first request. Each request is then
// stepped through the states that read and write the pool memories;
// first and next step over each dead entry they skip, and clean steps
// through each queued handle. One request is worked on at a time; a
// finished result sits in an output register, so the next request is
// taken while it waits.
module object_pool_handle_allocator_unit #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // req_type[2:0], handle[12:3], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // result_handle[9:0], status[11:10],
                                      // reclaimed_count[22:12], dead_flag[23]
);
  import opha_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  opha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  opha_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== tb/object_pool_handle_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// object_pool_handle_allocator_checker
// Watches both stream channels of the handle allocator. It predicts each
// result from its own copy of the pool state and compares it field by field.
// ----------------------------------------------------------------------------
module object_pool_handle_allocator_checker #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o
);
  import opha_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                dead_flag;
    logic [CountW-1:0]   reclaimed;
    logic [StatusW-1:0]  status;
    logic [HandleW-1:0]  handle;
  } pool_result_t;

  localparam int unsigned NullLink = CAPACITY;

  int unsigned  free_slots [CAPACITY];
  int unsigned  free_depth;
  bit           dead_bits  [CAPACITY];
  int unsigned  next_link  [CAPACITY];
  int unsigned  prev_link  [CAPACITY];
  int unsigned  list_head;
  int unsigned  free_queue [CAPACITY];
  int unsigned  free_queue_cnt;
  int           fail_count = 0;
  pool_result_t expected_results [$];

  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      free_slots[i] = i;
      dead_bits[i]  = 1'b1;
      next_link[i]  = NullLink;
      prev_link[i]  = NullLink;
    end
    free_depth     = CAPACITY;
    list_head      = NullLink;
    free_queue_cnt = 0;
  end

  assign fail_count_o = fail_count;

  function automatic int unsigned find_live(int unsigned start);
    int unsigned p;
    int unsigned steps;
    p = start;
    steps = 0;
    while (p < CAPACITY && dead_bits[p]) begin
      if (steps >= CAPACITY) return NullLink;
      steps++;
      p = next_link[p];
    end
    return (p < CAPACITY) ? p : NullLink;
  endfunction

  function automatic pool_result_t pool_predict(logic [ReqW-1:0] req,
                                                int unsigned h);
    pool_result_t r;
    int unsigned  s, nx, pv, f, n;
    r = '0;
    case (req)
      REQ_ALLOC: begin
        if (free_depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          free_depth--;
          s = free_slots[free_depth];
          dead_bits[s] = 1'b0;
          if (list_head < CAPACITY) prev_link[list_head] = s;
          prev_link[s] = NullLink;
          next_link[s] = list_head;
          list_head = s;
          r.handle = HandleW'(s);
        end
      end
      REQ_FREE: begin
        if (h >= CAPACITY || dead_bits[h]) begin
          r.status = ST_DBL;
        end else begin
          dead_bits[h] = 1'b1;
          if (free_queue_cnt < CAPACITY) begin
            free_queue[free_queue_cnt] = h;
            free_queue_cnt++;
          end
        end
      end
      REQ_CLEAN: begin
        n = free_queue_cnt;
        for (int i = 0; i < n; i++) begin
          s  = free_queue[i];
          nx = next_link[s];
          pv = prev_link[s];
          if (nx < CAPACITY) prev_link[nx] = pv;
          if (pv < CAPACITY) next_link[pv] = nx;
          if (list_head == s) list_head = nx;
          if (free_depth < CAPACITY) begin
            free_slots[free_depth] = s;
            free_depth++;
          end
          r.reclaimed++;
        end
        free_queue_cnt = 0;
      end
      REQ_FIRST, REQ_NEXT: begin
        if (req == REQ_FIRST) f = find_live(list_head);
        else f = find_live((h < CAPACITY) ? next_link[h] : NullLink);
        if (f < CAPACITY) r.handle = HandleW'(f);
        else r.status = ST_END;
      end
      REQ_DEAD: r.dead_flag = (h < CAPACITY) ? dead_bits[h] : 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    pool_result_t got;
    pool_result_t want;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      expected_results.push_back(pool_predict(s_axis_tdata[2:0], s_axis_tdata[12:3]));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result transfer", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.handle !== want.handle)
          report_mismatch("result_handle", got.handle, want.handle);
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
        if (got.reclaimed !== want.reclaimed)
          report_mismatch("reclaimed_count", got.reclaimed, want.reclaimed);
        if (got.dead_flag !== want.dead_flag)
          report_mismatch("dead_flag", got.dead_flag, want.dead_flag);
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// ===== tb/tb_object_pool_handle_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_object_pool_handle_allocator_unit
// Drives allocate/free/clean/walk/query traffic with random bursts and output
// stalls, including a long hold-off, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_object_pool_handle_allocator_unit;
  import opha_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IdleLimit = 20000;
  localparam logic [ReqW-1:0] ReqUnusedA = 3'd6;
  localparam logic [ReqW-1:0] ReqUnusedB = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  bit          hold_off = 1'b0;
  bit          stim_done = 1'b0;
  bit          rand_phase = 1'b0;
  int unsigned idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  object_pool_handle_allocator_unit #(.CAPACITY(CAPACITY)) dut (.*);

  object_pool_handle_allocator_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // one transfer; gap cycles before it idle the input
  task automatic send_req(logic [ReqW-1:0] req, logic [HandleW-1:0] h, int gap);
    repeat (gap) @(posedge clk_i) s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, h, req};
    do @(posedge clk_i); while (!s_axis_tready);
    s_axis_tvalid <= 1'b0;
  endtask

  // burst mode: keep valid up across back-to-back transfers
  task automatic burst_req(logic [ReqW-1:0] req, logic [HandleW-1:0] h);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, h, req};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [ReqW-1:0] pick_req();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return REQ_ALLOC;
    if (r < 52) return REQ_FREE;
    if (r < 58) return REQ_CLEAN;
    if (r < 68) return REQ_FIRST;
    if (r < 83) return REQ_NEXT;
    if (r < 97) return REQ_DEAD;
    return ($urandom_range(1) != 0) ? ReqUnusedB : ReqUnusedA;
  endfunction

  function automatic logic [HandleW-1:0] pick_handle();
    // mostly low slots, sometimes anywhere
    if ($urandom_range(3) == 0) return HandleW'($urandom_range(CAPACITY - 1));
    return HandleW'($urandom_range(63));
  endfunction

  // receiver: random stall pattern, plus long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if (stim_done) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(3) != 0);
  end

  // long hold-off while random traffic keeps coming
  initial begin
    wait (rand_phase);
    repeat (20) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit + 4 * CAPACITY) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int burst;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes and special cases
    send_req(REQ_FIRST, 10'd0, 0);          // empty list walk
    send_req(REQ_FREE, 10'd1023, 0);        // never allocated -> double free
    send_req(REQ_DEAD, 10'd1023, 0);
    send_req(REQ_NEXT, 10'd1023, 1);        // null link
    send_req(REQ_CLEAN, 10'd0, 0);          // nothing queued
    send_req(ReqUnusedA, 10'h3ff, 0);
    send_req(ReqUnusedB, 10'h155, 2);
    send_req(REQ_ALLOC, 10'h2aa, 0);
    send_req(REQ_ALLOC, 10'd0, 0);
    send_req(REQ_ALLOC, 10'd0, 0);
    send_req(REQ_DEAD, 10'd1022, 0);
    send_req(REQ_FREE, 10'd1022, 0);        // middle entry
    send_req(REQ_FREE, 10'd1022, 0);        // double free
    send_req(REQ_FIRST, 10'd0, 0);
    send_req(REQ_NEXT, 10'd1021, 0);        // skips dead middle
    send_req(REQ_NEXT, 10'd1023, 0);        // tail
    send_req(REQ_FREE, 10'd1021, 0);
    send_req(REQ_CLEAN, 10'd0, 0);
    send_req(REQ_NEXT, 10'd1022, 0);        // stale link of unlinked slot
    send_req(REQ_FREE, 10'd1023, 0);
    send_req(REQ_CLEAN, 10'd0, 0);

    // drain the pool completely, then hit the empty case
    for (int i = 0; i < CAPACITY; i++) burst_req(REQ_ALLOC, 10'd0);
    burst_req(REQ_ALLOC, 10'd0);
    burst_req(REQ_DEAD, 10'd0);
    for (int i = 0; i < CAPACITY; i += 8) burst_req(REQ_FREE, HandleW'(i));
    burst_req(REQ_CLEAN, 10'd0);
    s_axis_tvalid <= 1'b0;

    // random bursts
    rand_phase <= 1'b1;
    for (int n = 0; n < 170; ) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++, n++) burst_req(pick_req(), pick_handle());
      s_axis_tvalid <= 1'b0;
      if ($urandom_range(2) != 0) repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b0;
    stim_done <= 1'b1;

    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
